>>> sv/tsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the tone sequence player.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int FREQ_W  = 20;
    localparam int MS_W    = 16;
    localparam int IDX_W   = 6;
    localparam int LEN_W   = 7;
    localparam int RUN_W   = 8;
    localparam int ENTRY_W = FREQ_W + MS_W + MS_W;

    localparam logic [FREQ_W-1:0] RESET_FREQ = 20'd25088;
    localparam logic [LEN_W-1:0]  RESET_LEN  = 7'd64;

    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_START  = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_MANUAL = 3'd3,
        ACT_LOAD   = 3'd4
    } action_t;

    typedef struct packed {
        logic            ge;
        logic            timer_zero;
        logic [MS_W-1:0] elapsed_left;
        logic [MS_W-1:0] timer_left;
    } step_res_t;

endpackage

>>> sv/tsp_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module tsp_ram #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> sv/tsp_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_step_unit
// Shared subtract and compare of elapsed time against the phase timer.
// ----------------------------------------------------------------------------
module tsp_step_unit (
    input  logic [tsp_pkg::MS_W-1:0] elapsed,
    input  logic [tsp_pkg::MS_W-1:0] timer,
    output tsp_pkg::step_res_t       res
);
    import tsp_pkg::*;

    logic [MS_W:0] diff;

    assign diff             = {1'b0, elapsed} - {1'b0, timer};
    assign res.ge           = ~diff[MS_W];
    assign res.timer_zero   = (timer == '0);
    assign res.elapsed_left = diff[MS_W-1:0];
    assign res.timer_left   = timer - elapsed;

endmodule

>>> sv/tone_sequence_player_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tone_sequence_player_unit
// Note table player: load events, start, stop, manual note, timed ticks.
// ----------------------------------------------------------------------------
// Input words arrive on s_t*: the command sits in s_tuser, its operands in
// s_tdata. Every accepted word yields exactly one result word on m_t*.
// cfg_* writes the melody length; it is always ready. It must be written
// only while the player is idle; the block itself does not enforce this.
// Load, stop, manual note, unknown codes and an idle tick go straight to the
// result stage; start first reads table entry 0. An active tick passes
// through the subtract and boundary states once per phase boundary it
// crosses: each boundary is one pass through the shared subtractor plus one
// table read. A tick crosses at most 2*L boundaries in a row that consume
// no time, L being the length taken as 1 for 0 and capped at MAX_EVENTS.
// One word is worked at a time; s_tready is low until its result is in the
// output register. The output register holds a result until m_tready; a
// new word is taken while a result waits, and its result holds until the
// register frees. Reset clears the player to stopped at event 0, note
// phase, with the 1568 Hz default note; the table is undefined until loaded.
// ----------------------------------------------------------------------------
module tone_sequence_player_unit #(
    parameter int MAX_EVENTS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // s_tdata: elapsed_ms, entry_index, entry_note, entry_on_ms,
    //          entry_off_ms, manual_freq
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [95:0]               s_tdata,
    // s_tuser: action
    input  logic [2:0]                s_tuser,
    // m_tdata: note_freq, playing, position, sounding
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [tsp_pkg::LEN_W-1:0] cfg_data
);
    import tsp_pkg::*;

    localparam int AW = $clog2(MAX_EVENTS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_TICK,
        ST_BOUND,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    len_reg;
    logic                active_reg, active_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [MS_W-1:0]     timer_reg, timer_next;
    logic                note_ph_reg, note_ph_next;
    logic [FREQ_W-1:0]   manual_reg, manual_next;
    logic [FREQ_W-1:0]   freq_reg, freq_next;
    logic [MS_W-1:0]     elapsed_reg, elapsed_next;
    logic [RUN_W-1:0]    run_reg, run_next;
    logic                m_valid_reg, m_valid_next;
    logic [31:0]         m_data_reg, m_data_next;

    logic                s_accept;
    action_t             action;
    logic [IDX_W-1:0]    in_idx;
    logic [MS_W-1:0]     in_elapsed;
    logic [FREQ_W-1:0]   in_note;
    logic [MS_W-1:0]     in_on;
    logic [MS_W-1:0]     in_off;
    logic [FREQ_W-1:0]   in_manual;

    logic [LEN_W-1:0]    eff_len;
    logic [RUN_W-1:0]    run_limit;
    logic [AW:0]         pos_inc;
    logic [AW-1:0]       pos_wrap;
    logic [AW+IDX_W-1:0] idx_wide;
    logic [AW+IDX_W-1:0] pos_wide;

    logic                wr_en;
    logic [AW-1:0]       rd_addr;
    logic [ENTRY_W-1:0]  rd_data;
    logic [FREQ_W-1:0]   rd_note;
    logic [MS_W-1:0]     rd_on;
    logic [MS_W-1:0]     rd_off;
    step_res_t           step;

    assign s_accept   = s_tvalid & s_tready;
    assign action     = action_t'(s_tuser);
    assign in_elapsed = s_tdata[15:0];
    assign in_idx     = s_tdata[21:16];
    assign in_note    = s_tdata[41:22];
    assign in_on      = s_tdata[57:42];
    assign in_off     = s_tdata[73:58];
    assign in_manual  = s_tdata[93:74];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    always_comb begin
        if (len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (32'(len_reg) > MAX_EVENTS) begin
            eff_len = LEN_W'(MAX_EVENTS);
        end else begin
            eff_len = len_reg;
        end
    end

    assign run_limit = {eff_len, 1'b0};
    assign pos_inc   = {1'b0, pos_reg} + 1'b1;
    assign pos_wrap  = (32'(pos_inc) >= 32'(eff_len)) ? '0 : pos_inc[AW-1:0];
    assign idx_wide  = {{AW{1'b0}}, in_idx};
    assign pos_wide  = {{IDX_W{1'b0}}, pos_reg};

    assign wr_en = s_accept && (action == ACT_LOAD) && (32'(in_idx) < MAX_EVENTS);

    always_comb begin
        rd_addr = '0;
        if (state_reg == ST_TICK) begin
            rd_addr = note_ph_reg ? pos_reg : pos_wrap;
        end
    end

    tsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_EVENTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_wide[AW-1:0]),
        .wr_data ({in_off, in_on, in_note}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_note = rd_data[FREQ_W-1:0];
    assign rd_on   = rd_data[FREQ_W+MS_W-1:FREQ_W];
    assign rd_off  = rd_data[ENTRY_W-1:FREQ_W+MS_W];

    tsp_step_unit u_step (
        .elapsed (elapsed_reg),
        .timer   (timer_reg),
        .res     (step)
    );

    always_comb begin
        state_next   = state_reg;
        active_next  = active_reg;
        pos_next     = pos_reg;
        timer_next   = timer_reg;
        note_ph_next = note_ph_reg;
        manual_next  = manual_reg;
        freq_next    = freq_reg;
        elapsed_next = elapsed_reg;
        run_next     = run_reg;
        m_valid_next = m_valid_reg & ~m_tready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    elapsed_next = in_elapsed;
                    run_next     = '0;
                    state_next   = ST_DONE;
                    case (action)
                        ACT_TICK: begin
                            if (active_reg) begin
                                state_next = ST_TICK;
                            end else begin
                                freq_next = manual_reg;
                            end
                        end
                        ACT_START: begin
                            state_next = ST_START;
                        end
                        ACT_STOP: begin
                            active_next = 1'b0;
                        end
                        ACT_MANUAL: begin
                            manual_next = in_manual;
                            freq_next   = in_manual;
                            active_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_START: begin
                active_next  = 1'b1;
                pos_next     = '0;
                note_ph_next = 1'b1;
                timer_next   = rd_on;
                freq_next    = rd_note;
                state_next   = ST_DONE;
            end
            ST_TICK: begin
                if (elapsed_reg == '0) begin
                    state_next = ST_DONE;
                end else if (step.ge) begin
                    elapsed_next = step.elapsed_left;
                    timer_next   = '0;
                    run_next     = step.timer_zero ? run_reg + 1'b1 : '0;
                    state_next   = ST_BOUND;
                end else begin
                    timer_next   = step.timer_left;
                    elapsed_next = '0;
                    state_next   = ST_DONE;
                end
            end
            ST_BOUND: begin
                if (note_ph_reg) begin
                    note_ph_next = 1'b0;
                    timer_next   = rd_off;
                    freq_next    = '0;
                end else begin
                    note_ph_next = 1'b1;
                    pos_next     = pos_wrap;
                    timer_next   = rd_on;
                    freq_next    = rd_note;
                end
                if (run_reg >= run_limit) begin
                    elapsed_next = '0;
                end
                state_next = ST_TICK;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {4'b0, note_ph_reg, pos_wide[IDX_W-1:0], active_reg,
                                    freq_reg};
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= RESET_LEN;
            active_reg  <= 1'b0;
            pos_reg     <= '0;
            timer_reg   <= '0;
            note_ph_reg <= 1'b1;
            manual_reg  <= RESET_FREQ;
            freq_reg    <= RESET_FREQ;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_valid && cfg_ready) begin
                len_reg <= cfg_data;
            end
            active_reg  <= active_next;
            pos_reg     <= pos_next;
            timer_reg   <= timer_next;
            note_ph_reg <= note_ph_next;
            manual_reg  <= manual_next;
            freq_reg    <= freq_next;
            m_valid_reg <= m_valid_next;
        end
        elapsed_reg <= elapsed_next;
        run_reg     <= run_next;
        m_data_reg  <= m_data_next;
    end

`ifndef ASSERT_OFF
    a_one_word: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input word taken while another is in work");

    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BOUND) |-> (run_reg <= run_limit))
        else $error("zero-time boundary run overshot its limit");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(pos_reg) < MAX_EVENTS)
        else $error("event position beyond table depth");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside completion");
`endif

endmodule

>>> bench/tsp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsp_checker
// Watches the command, result and length channels of the tone sequence
// player. It keeps its own copy of the player state and note table, works
// out the result of every accepted command word, and compares each result
// word against the oldest outstanding prediction field by field.
// ----------------------------------------------------------------------------
module tsp_checker #(
    parameter int MAX_EVENTS = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [95:0]               s_tdata,
    input  logic [2:0]                s_tuser,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [31:0]               m_tdata,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [tsp_pkg::LEN_W-1:0] cfg_data,
    output int                        n_fail,
    output int                        n_pending
);
    import tsp_pkg::*;

    typedef struct packed {
        logic              sounding;
        logic [IDX_W-1:0]  position;
        logic              playing;
        logic [FREQ_W-1:0] freq;
    } tone_t;

    logic [FREQ_W-1:0] note_mem [MAX_EVENTS];
    logic [MS_W-1:0]   on_mem   [MAX_EVENTS];
    logic [MS_W-1:0]   off_mem  [MAX_EVENTS];

    logic [LEN_W-1:0]  song_len;
    logic              active;
    logic [IDX_W-1:0]  pos;
    logic [MS_W-1:0]   timer;
    logic              in_note;
    logic [FREQ_W-1:0] held_freq;
    logic [FREQ_W-1:0] cur_freq;

    tone_t tone_q [$];
    int    fail_cnt = 0;
    int    shown    = 0;

    assign n_fail = fail_cnt;

    function automatic int unsigned span();
        if (song_len == '0)
            return 1;
        if (song_len > MAX_EVENTS)
            return MAX_EVENTS;
        return 32'(song_len);
    endfunction

    function automatic void cross_boundary();
        int unsigned nxt;
        if (in_note) begin
            in_note  = 1'b0;
            timer    = off_mem[pos];
            cur_freq = '0;
        end else begin
            nxt = pos + 1;
            if (nxt >= span())
                nxt = 0;
            pos      = nxt[IDX_W-1:0];
            in_note  = 1'b1;
            timer    = on_mem[pos];
            cur_freq = note_mem[pos];
        end
    endfunction

    function automatic void advance_time(input logic [MS_W-1:0] elapsed);
        int unsigned rem;
        int unsigned zero_run;
        int unsigned lim;
        rem      = 32'(elapsed);
        zero_run = 0;
        lim      = 2 * span();
        if (!active) begin
            cur_freq = held_freq;
            return;
        end
        while (rem != 0) begin
            if (rem >= timer) begin
                if (timer == '0)
                    zero_run++;
                else
                    zero_run = 0;
                rem   = rem - timer;
                timer = '0;
                cross_boundary();
                // drop leftover time once a whole pass consumed nothing
                if (zero_run >= lim)
                    rem = 0;
            end else begin
                timer = timer - rem[MS_W-1:0];
                rem   = 0;
            end
        end
    endfunction

    function automatic tone_t play_word(input logic [2:0] act, input logic [95:0] d);
        tone_t r;
        case (act)
            ACT_TICK: begin
                advance_time(d[15:0]);
            end
            ACT_START: begin
                active   = 1'b1;
                pos      = '0;
                in_note  = 1'b1;
                timer    = on_mem[0];
                cur_freq = note_mem[0];
            end
            ACT_STOP: begin
                active = 1'b0;
            end
            ACT_MANUAL: begin
                held_freq = d[93:74];
                active    = 1'b0;
                cur_freq  = d[93:74];
            end
            ACT_LOAD: begin
                if (d[21:16] < MAX_EVENTS) begin
                    note_mem[d[21:16]] = d[41:22];
                    on_mem[d[21:16]]   = d[57:42];
                    off_mem[d[21:16]]  = d[73:58];
                end
            end
            default: begin
            end
        endcase
        r.freq     = cur_freq;
        r.playing  = active;
        r.position = pos;
        r.sounding = in_note;
        return r;
    endfunction

    always @(posedge aclk) begin
        tone_t want;
        tone_t got;
        if (!aresetn) begin
            song_len  = RESET_LEN;
            active    = 1'b0;
            pos       = '0;
            timer     = '0;
            in_note   = 1'b1;
            held_freq = RESET_FREQ;
            cur_freq  = RESET_FREQ;
            tone_q.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                song_len = cfg_data;
            if (s_tvalid && s_tready)
                tone_q.push_back(play_word(s_tuser, s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[27:0];
                if (tone_q.size() == 0) begin
                    fail_cnt++;
                    if (shown < 10)
                        $display("unexpected result word: freq %0h playing %0b pos %0d snd %0b",
                                 got.freq, got.playing, got.position, got.sounding);
                    shown++;
                end else begin
                    want = tone_q.pop_front();
                    if (got.freq !== want.freq || got.playing !== want.playing ||
                        got.position !== want.position || got.sounding !== want.sounding) begin
                        fail_cnt++;
                        if (shown < 10)
                            $display({"result mismatch: exp freq %0h playing %0b pos %0d snd %0b,",
                                      " got freq %0h playing %0b pos %0d snd %0b"},
                                     want.freq, want.playing, want.position, want.sounding,
                                     got.freq, got.playing, got.position, got.sounding);
                        shown++;
                    end
                end
            end
        end
        n_pending <= tone_q.size();
    end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the tone sequence player with a directed command list and then
// random command streams under several melody lengths and handshake idling
// patterns; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import tsp_pkg::*;

    localparam int MAX_EVENTS = 64;

    typedef struct packed {
        logic [FREQ_W-1:0] manual;
        logic [MS_W-1:0]   off_ms;
        logic [MS_W-1:0]   on_ms;
        logic [FREQ_W-1:0] note;
        logic [IDX_W-1:0]  idx;
        logic [MS_W-1:0]   elapsed;
    } cmd_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [95:0]       s_tdata   = '0;
    logic [2:0]        s_tuser   = ACT_TICK;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [31:0]       m_tdata;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [LEN_W-1:0]  cfg_data  = '0;

    int n_fail;
    int n_pending;
    int gap_pct   = 0;
    int stall_pct = 0;

    bit written [MAX_EVENTS];
    int len_now = int'(RESET_LEN);
    bit running = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    tone_sequence_player_unit #(.MAX_EVENTS(MAX_EVENTS)) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    tsp_checker #(.MAX_EVENTS(MAX_EVENTS)) i_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .n_fail    (n_fail),
        .n_pending (n_pending)
    );

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic cmd_t cmd(input logic [MS_W-1:0] elapsed, input logic [IDX_W-1:0] idx,
                                 input logic [FREQ_W-1:0] note, input logic [MS_W-1:0] on_ms,
                                 input logic [MS_W-1:0] off_ms, input logic [FREQ_W-1:0] manual);
        cmd_t c;
        c.elapsed = elapsed;
        c.idx     = idx;
        c.note    = note;
        c.on_ms   = on_ms;
        c.off_ms  = off_ms;
        c.manual  = manual;
        return c;
    endfunction

    function automatic int span_of(input int len);
        if (len == 0)
            return 1;
        if (len > MAX_EVENTS)
            return MAX_EVENTS;
        return len;
    endfunction

    // lowest table slot the given length would read before it is loaded, or -1
    function automatic int first_hole(input int len);
        for (int i = 0; i < span_of(len); i++)
            if (!written[i])
                return i;
        return -1;
    endfunction

    function automatic logic [MS_W-1:0] pick_ms();
        int r;
        r = $urandom_range(15);
        if (r < 2)
            return '0;
        if (r == 2)
            return MS_W'($urandom);
        return MS_W'($urandom_range(30, 1));
    endfunction

    task automatic send_word(input logic [2:0] act, input cmd_t w);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, w};
        do @(posedge aclk); while (!s_tready);
        case (act)
            ACT_START:             running = 1'b1;
            ACT_STOP, ACT_MANUAL:  running = 1'b0;
            ACT_LOAD:              written[w.idx] = 1'b1;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_pending != 0)
            @(posedge aclk);
    endtask

    task automatic set_length(input int len);
        if (running && first_hole(len) >= 0)
            send_word(ACT_STOP, cmd(0, 0, 0, 0, 0, 0));
        drain();
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len[LEN_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        len_now = len;
    endtask

    task automatic random_word();
        cmd_t        w;
        logic [2:0]  act;
        int          k;
        int          hole;
        w    = cmd(MS_W'($urandom), IDX_W'($urandom), FREQ_W'($urandom), pick_ms(), pick_ms(),
                   FREQ_W'($urandom));
        k    = $urandom_range(99);
        hole = first_hole(len_now);
        if (k < 45) begin
            act = ACT_TICK;
            if (running) begin
                if ($urandom_range(199) == 0)
                    w.elapsed = MS_W'($urandom);
                else if ($urandom_range(9) == 0)
                    w.elapsed = '0;
                else
                    w.elapsed = MS_W'($urandom_range(40));
            end
        end else if (k < 72) begin
            act = ACT_LOAD;
            if (hole >= 0 && $urandom_range(1) == 0)
                w.idx = IDX_W'(hole);
        end else if (k < 84) begin
            act = ACT_START;
            if (hole >= 0) begin
                act   = ACT_LOAD;
                w.idx = IDX_W'(hole);
            end
        end else if (k < 90) begin
            act = ACT_STOP;
        end else if (k < 96) begin
            act = ACT_MANUAL;
        end else begin
            act = ACT_LOAD + 3'($urandom_range(3, 1));
        end
        send_word(act, w);
    endtask

    initial begin
        #200_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int lens [8];
        lens = '{64, 2, 127, 1, 0, 5, 33, 65};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: idle behavior, table extremes, playback, wrap, zero-time pass
        set_length(3);
        send_word(ACT_TICK,   cmd(16'h1234, 0, 0, 0, 0, 0));
        send_word(ACT_MANUAL, cmd(0, 0, 0, 0, 0, 20'hFFFFF));
        send_word(ACT_TICK,   cmd(16'hFFFF, 6'h3F, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 0));
        send_word(ACT_STOP,   cmd(0, 0, 0, 0, 0, 0));
        send_word(ACT_LOAD + 3'd1, cmd(16'hFFFF, 6'h3F, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 20'hFFFFF));
        send_word(ACT_LOAD + 3'd3, cmd(0, 0, 0, 0, 0, 0));
        send_word(ACT_LOAD,   cmd(0, 0, 20'hFFFFF, 16'hFFFF, 16'h0001, 0));
        send_word(ACT_LOAD,   cmd(0, 1, 20'h00000, 16'h0000, 16'hFFFF, 0));
        send_word(ACT_LOAD,   cmd(0, 2, 20'h12345, 16'h0003, 16'h0000, 0));
        send_word(ACT_LOAD,   cmd(0, 6'h3F, 20'hFFFFF, 16'hFFFF, 16'hFFFF, 0));
        send_word(ACT_START,  cmd(0, 0, 0, 0, 0, 0));
        send_word(ACT_TICK,   cmd(16'h0000, 0, 0, 0, 0, 0));
        send_word(ACT_TICK,   cmd(16'hFFFF, 0, 0, 0, 0, 0));
        send_word(ACT_TICK,   cmd(16'h0001, 0, 0, 0, 0, 0));
        send_word(ACT_TICK,   cmd(16'h0001, 0, 0, 0, 0, 0));
        send_word(ACT_TICK,   cmd(16'hFFFE, 0, 0, 0, 0, 0));
        set_length(1);
        send_word(ACT_TICK,   cmd(16'h0003, 0, 0, 0, 0, 0));
        send_word(ACT_TICK,   cmd(16'h0001, 0, 0, 0, 0, 0));
        send_word(ACT_STOP,   cmd(0, 0, 0, 0, 0, 0));
        send_word(ACT_TICK,   cmd(16'h0005, 0, 0, 0, 0, 0));
        send_word(ACT_MANUAL, cmd(0, 0, 0, 0, 0, 20'h00000));
        send_word(ACT_LOAD,   cmd(0, 0, 20'h00007, 16'h0000, 16'h0000, 0));
        send_word(ACT_START,  cmd(0, 0, 0, 0, 0, 0));
        send_word(ACT_TICK,   cmd(16'h0005, 0, 0, 0, 0, 0));
        set_length(0);
        send_word(ACT_TICK,   cmd(16'hFFFF, 0, 0, 0, 0, 0));

        for (int ph = 0; ph < 8; ph++) begin
            set_length(lens[ph]);
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 84; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 84; end
                default: begin gap_pct = 29; stall_pct = 29; end
            endcase
            for (int n = 0; n < 205; n++) begin
                // hold the sender until everything in flight has returned
                if (n == 102)
                    drain();
                random_word();
            end
        end

        drain();
        repeat (40) @(posedge aclk);
        if (n_fail == 0 && n_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
